// ===== design/pngr_pkg.sv =====
// shared types and codes for the png row filter reconstruction block
package pngr_pkg;

   // width of the column index carried between front and back
   localparam int COL_BITS = 16;

   // row filter codes
   typedef enum logic [2:0] {
      FILT_NONE  = 3'd0,
      FILT_SUB   = 3'd1,
      FILT_UP    = 3'd2,
      FILT_AVG   = 3'd3,
      FILT_PAETH = 3'd4
   } filt_type;

   // highest filter code that is supported
   localparam logic [7:0] FILT_MAX = 8'd4;

   // result status codes
   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_BAD_FILTER = 2'd1,
      ST_SHORT_ROW  = 2'd2
   } status_type;

   // one work item passed from front to back
   typedef struct packed {
      logic [7:0]          data;
      filt_type            filt;
      logic [COL_BITS-1:0] col;
      logic                use_above;
      logic                do_recon;
      status_type          status;
      logic                last;
   } cmd_type;

endpackage

// ===== design/pngr_front.sv =====
// front end: row and column tracking, filter decode and status classification
module pngr_front
   import pngr_pkg::*;
#(
   parameter int MAX_ROW_WIDTH = 4096
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_wr_en,
   input  logic [12:0]   csr_wr_data,
   input  logic          in_valid,
   input  logic [7:0]    in_byte,
   input  logic          in_eos,
   output logic          in_ready,
   input  logic          q_full,
   output logic          q_push,
   output cmd_type       q_cmd
);

   localparam int CW = $clog2(MAX_ROW_WIDTH + 1);
   localparam int WW = (CW > 13) ? CW : 13;
   localparam int AW = (MAX_ROW_WIDTH > 1) ? $clog2(MAX_ROW_WIDTH) : 1;

   logic [12:0]   row_width_ff;
   logic [AW-1:0] col_ff, col_in;
   logic          expect_ff, expect_in;
   logic          first_row_ff, first_row_in;
   filt_type      filt_ff, filt_in;
   logic          bad_ff, bad_in;

   logic [WW-1:0] raw_width;
   logic [WW-1:0] eff_width;
   logic [WW-1:0] col_inc;
   logic          row_end;
   logic          accept;

   // clamp the configured width into the supported range
   assign raw_width = WW'(row_width_ff);
   always_comb begin
      if (raw_width == '0) begin
         eff_width = WW'(1);
      end else if (raw_width > WW'(MAX_ROW_WIDTH)) begin
         eff_width = WW'(MAX_ROW_WIDTH);
      end else begin
         eff_width = raw_width;
      end
   end

   assign col_inc  = WW'(col_ff) + WW'(1);
   assign row_end  = (col_inc >= eff_width);
   assign in_ready = !q_full;
   assign accept   = in_valid && in_ready;

   // classify the byte and work out the next row state
   always_comb begin
      col_in       = col_ff;
      expect_in    = expect_ff;
      first_row_in = first_row_ff;
      filt_in      = filt_ff;
      bad_in       = bad_ff;
      q_push       = 1'b0;
      q_cmd.data      = in_byte;
      q_cmd.filt      = filt_ff;
      q_cmd.col       = COL_BITS'(col_ff);
      q_cmd.use_above = !first_row_ff;
      q_cmd.do_recon  = 1'b0;
      q_cmd.status    = ST_OK;
      q_cmd.last      = in_eos;
      if (accept) begin
         if (expect_ff) begin
            // filter byte
            if (in_byte > FILT_MAX) begin
               bad_in  = 1'b1;
               filt_in = FILT_NONE;
            end else begin
               filt_in = filt_type'(in_byte[2:0]);
            end
            col_in    = '0;
            expect_in = 1'b0;
            if (in_eos) begin
               q_push       = 1'b1;
               q_cmd.status = ST_SHORT_ROW;
            end
         end else begin
            // data byte
            q_cmd.do_recon = !bad_ff;
            q_push         = !bad_ff || in_eos;
            if (in_eos) begin
               if (!row_end) begin
                  q_cmd.status = ST_SHORT_ROW;
               end else if (bad_ff) begin
                  q_cmd.status = ST_BAD_FILTER;
               end
            end
            if (row_end) begin
               col_in       = '0;
               expect_in    = 1'b1;
               first_row_in = 1'b0;
            end else begin
               col_in = AW'(col_inc);
            end
         end
         if (in_eos) begin
            col_in       = '0;
            expect_in    = 1'b1;
            first_row_in = 1'b1;
            filt_in      = FILT_NONE;
            bad_in       = 1'b0;
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff <= 13'd1;
         col_ff       <= '0;
         expect_ff    <= 1'b1;
         first_row_ff <= 1'b1;
         filt_ff      <= FILT_NONE;
         bad_ff       <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            row_width_ff <= csr_wr_data;
         end
         col_ff       <= col_in;
         expect_ff    <= expect_in;
         first_row_ff <= first_row_in;
         filt_ff      <= filt_in;
         bad_ff       <= bad_in;
      end
   end

endmodule

// ===== design/pngr_fifo.sv =====
// short command queue between front and back
module pngr_fifo
   import pngr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    not_empty,
   output cmd_type head_cmd
);

   localparam int DEPTH = 4;
   localparam int PW    = $clog2(DEPTH);

   cmd_type         slot_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PW:0]     count_ff, count_in;
   logic            do_push;
   logic            do_pop;

   assign full      = (count_ff == (PW + 1)'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_cmd  = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (PW + 1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (PW + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== design/pngr_back.sv =====
// back end: line store read, filter reconstruction and result register
module pngr_back
   import pngr_pkg::*;
#(
   parameter int MAX_ROW_WIDTH = 4096
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       q_valid,
   input  cmd_type    q_cmd,
   output logic       q_pop,
   output logic       out_valid,
   input  logic       out_ready,
   output logic [7:0] out_byte,
   output status_type out_status,
   output logic       out_last
);

   localparam int AW = (MAX_ROW_WIDTH > 1) ? $clog2(MAX_ROW_WIDTH) : 1;

   logic [7:0]    line_mem [MAX_ROW_WIDTH];

   logic          s1_valid_ff, s1_valid_in;
   cmd_type       s1_cmd_ff;
   logic [7:0]    rd_ff;
   logic          rd_zero_ff;
   logic          byp_ff;
   logic [7:0]    byp_data_ff;
   logic [7:0]    left_ff;
   logic [7:0]    ul_ff;
   logic [AW:0]   fill_ff, fill_in;
   logic          out_valid_ff, out_valid_in;
   logic [7:0]    out_byte_ff;
   status_type    out_status_ff;
   logic          out_last_ff;

   logic          out_free;
   logic          s1_adv;
   logic          load;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] wr_addr;
   logic          wr_en;
   logic          row_start;
   logic [7:0]    above_raw;
   logic [7:0]    a_val, b_val, c_val;
   logic [7:0]    pred;
   logic [7:0]    recon;

   // paeth predictor on left, above and upper-left
   function automatic logic [7:0] paeth_pred(input logic [7:0] a, input logic [7:0] b,
                                             input logic [7:0] c);
      logic signed [9:0] da;
      logic signed [9:0] db;
      logic signed [9:0] dc;
      logic [9:0]        pa;
      logic [9:0]        pb;
      logic [9:0]        pc;
      da = $signed({2'b00, b}) - $signed({2'b00, c});
      db = $signed({2'b00, a}) - $signed({2'b00, c});
      dc = da + db;
      pa = (da < 0) ? 10'(-da) : 10'(da);
      pb = (db < 0) ? 10'(-db) : 10'(db);
      pc = (dc < 0) ? 10'(-dc) : 10'(dc);
      if (pa <= pb && pa <= pc) begin
         return a;
      end else if (pb <= pc) begin
         return b;
      end
      return c;
   endfunction

   // handshake between queue, stage 1 and the result register
   assign out_free = !out_valid_ff || out_ready;
   assign s1_adv   = s1_valid_ff && out_free;
   assign load     = q_valid && (!s1_valid_ff || s1_adv);
   assign q_pop    = load;
   assign s1_valid_in = load || (s1_valid_ff && !s1_adv);

   assign rd_addr = q_cmd.col[AW-1:0];
   assign wr_addr = s1_cmd_ff.col[AW-1:0];
   assign wr_en   = s1_adv && s1_cmd_ff.do_recon;

   // rows always write from column 0 upward, so the written entries form a prefix
   assign fill_in = (wr_en && ({1'b0, wr_addr} == fill_ff)) ? fill_ff + (AW + 1)'(1)
                                                            : fill_ff;

   // neighbor bytes, zero at the start of a row and on a stream's first row
   assign row_start = (s1_cmd_ff.col == '0);
   assign above_raw = byp_ff ? byp_data_ff : (rd_zero_ff ? 8'd0 : rd_ff);
   assign a_val     = row_start ? 8'd0 : left_ff;
   assign b_val     = s1_cmd_ff.use_above ? above_raw : 8'd0;
   assign c_val     = row_start ? 8'd0 : ul_ff;

   // prediction per filter type
   always_comb begin
      unique case (s1_cmd_ff.filt)
         FILT_NONE:  pred = 8'd0;
         FILT_SUB:   pred = a_val;
         FILT_UP:    pred = b_val;
         FILT_AVG:   pred = 8'((9'(a_val) + 9'(b_val)) >> 1);
         FILT_PAETH: pred = paeth_pred(a_val, b_val, c_val);
         default:    pred = 8'd0;
      endcase
   end

   assign recon = s1_cmd_ff.data + pred;

   // line store, registered read with bypass of a same-cycle write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[wr_addr] <= recon;
      end
      if (load) begin
         rd_ff       <= line_mem[rd_addr];
         rd_zero_ff  <= ({1'b0, rd_addr} >= fill_ff);
         byp_ff      <= wr_en && (wr_addr == rd_addr);
         byp_data_ff <= recon;
      end
   end

   // stage 1 command and left neighbor tracking
   always_ff @(posedge clock) begin
      if (load) begin
         s1_cmd_ff <= q_cmd;
      end
      if (wr_en) begin
         left_ff <= recon;
         ul_ff   <= b_val;
      end
   end

   // result register
   assign out_valid_in = s1_adv || (out_valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         out_byte_ff   <= (s1_cmd_ff.status == ST_OK) ? recon : 8'd0;
         out_status_ff <= s1_cmd_ff.status;
         out_last_ff   <= s1_cmd_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         fill_ff      <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         fill_ff      <= fill_in;
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_byte   = out_byte_ff;
   assign out_status = out_status_ff;
   assign out_last   = out_last_ff;

endmodule

// ===== design/png_predictor_reversal_top.sv =====
// PNG row filter reconstruction: one byte in, at most one reconstructed byte out.
// Each row is a filter byte followed by row_width data bytes; filters None, Sub, Up,
// Average and Paeth are undone against the previous row held in an on-chip line store
// of MAX_ROW_WIDTH bytes, which reads as zero on the first row of every stream.
// The block takes one byte per clock while the command queue has room and delivers one
// result per clock while rsp_tready is high; a data byte moves from the command queue
// into the line store read stage, then through reconstruction into the result register.
// The rate is set by the left-byte feedback in the reconstruction stage. A filter
// code above 4 suppresses results until end of stream; the result on the last byte
// carries the stream status (0 ok, 1 bad filter, 2 ended mid-row) and software drops
// the output if it is nonzero. Line store entries never written since reset read as
// zero through a fill mark over the written prefix, so no clearing pass is needed
// after reset.
module png_predictor_reversal_top
   import pngr_pkg::*;
#(
   parameter int MAX_ROW_WIDTH = 4096
) (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_wr_en,
   input  logic [12:0] csr_wr_data,   // row_width
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,     // [7:0] in_byte
   input  logic        req_tlast,     // end_of_stream
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,     // [7:0] out_byte, [9:8] status, [15:10] zero
   output logic        rsp_tlast      // last
);

   cmd_type    push_cmd;
   cmd_type    head_cmd;
   logic       push;
   logic       pop;
   logic       q_full;
   logic       q_not_empty;
   logic [7:0] out_byte;
   status_type out_status;

   // front: row tracking and classification
   pngr_front #(
      .MAX_ROW_WIDTH (MAX_ROW_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .in_valid    (req_tvalid),
      .in_byte     (req_tdata),
      .in_eos      (req_tlast),
      .in_ready    (req_tready),
      .q_full      (q_full),
      .q_push      (push),
      .q_cmd       (push_cmd)
   );

   // command queue
   pngr_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (q_full),
      .pop       (pop),
      .not_empty (q_not_empty),
      .head_cmd  (head_cmd)
   );

   // back: reconstruction and results
   pngr_back #(
      .MAX_ROW_WIDTH (MAX_ROW_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_not_empty),
      .q_cmd      (head_cmd),
      .q_pop      (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_byte   (out_byte),
      .out_status (out_status),
      .out_last   (rsp_tlast)
   );

   assign rsp_tdata = {6'd0, out_status, out_byte};

endmodule

// ===== design/pngr_checker.sv =====
// port-level checks for the png row filter reconstruction block
module pngr_checker
   import pngr_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tlast
);

   // no result is pending right after reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result pending after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // an error status only appears on the final transfer of a stream
   a_err_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[9:8] != ST_OK |-> rsp_tlast)
      else $error("error status before end of stream");

   // error results carry a zero byte and a defined status code
   a_err_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[9:8] == ST_OK || rsp_tdata[9:8] == ST_BAD_FILTER
                      || rsp_tdata[9:8] == ST_SHORT_ROW) && rsp_tdata[15:10] == 6'd0
                     && (rsp_tdata[9:8] == ST_OK || rsp_tdata[7:0] == 8'd0))
      else $error("malformed result word");

endmodule

bind png_predictor_reversal_top pngr_checker u_pngr_checker (.*);
